>>> hw/rtl/kpc_pkg.sv
// kpc_pkg: shared constants, payload types and controller command/status types
`default_nettype none

package kpc_pkg;

    // sample memory depth and derived widths
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 32;
    localparam int CLASS_W  = 23;
    localparam int PAIRS_W  = 13;

    localparam logic [CLASS_W-1:0] CLASS_MAX = {CLASS_W{1'b1}};

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_NODATA_FIRST     = 2'd0,
        REG_NODATA_FIRST_EN  = 2'd1,
        REG_NODATA_SECOND    = 2'd2,
        REG_NODATA_SECOND_EN = 2'd3
    } reg_index_t;

    // one input pixel pair
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_sample;
        logic signed [SAMPLE_W-1:0] second_sample;
        logic                       last_pixel;
    } item_t;

    // one result record
    typedef struct packed {
        logic [PAIRS_W-1:0] pair_count;
        logic [CLASS_W-1:0] concordant_count;
        logic [CLASS_W-1:0] discordant_count;
        logic [CLASS_W-1:0] tied_first_only;
        logic [CLASS_W-1:0] tied_second_only;
        logic [CLASS_W-1:0] tied_both;
        logic               overflowed;
        logic               status;
    } result_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PIVOT,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic              store;      // accept the item on the input port
        logic              rd_pivot;   // read issued is the pivot entry
        logic              rd_cmp;     // read issued is a compare entry
        logic [ADDR_W-1:0] rd_addr;
        logic              emit;       // latch result and clear the frame
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/kpc_ram.sv
// kpc_ram: generic simple dual-port ram with registered read
`default_nettype none

module kpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/kpc_ctrl.sv
// kpc_ctrl: controller that sequences loading and the pairwise pass
`default_nettype none

module kpc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          last_pixel,
    input  kpc_pkg::stat_t     stat,
    output logic               busy,
    output kpc_pkg::cmd_t      cmd
);

    kpc_pkg::state_t state_reg, state_next;
    logic [kpc_pkg::ADDR_W-1:0] i_reg, i_next;
    logic [kpc_pkg::ADDR_W-1:0] j_reg, j_next;
    logic                       accept;
    logic                       j_at_end;
    logic                       i_at_end;

    assign accept   = start && (state_reg == kpc_pkg::ST_IDLE);
    assign j_at_end = ({1'b0, j_reg} == (stat.fill - kpc_pkg::FILL_W'(1)));
    assign i_at_end = ({1'b0, i_reg} == (stat.fill - kpc_pkg::FILL_W'(2)));

    // state register and index counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kpc_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // next state and index counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            kpc_pkg::ST_IDLE:
            begin
                if (accept && last_pixel)
                begin
                    state_next = kpc_pkg::ST_START;
                end
            end
            kpc_pkg::ST_START:
            begin
                i_next = '0;
                if (stat.fill < kpc_pkg::FILL_W'(2))
                begin
                    state_next = kpc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = kpc_pkg::ST_PIVOT;
                end
            end
            kpc_pkg::ST_PIVOT:
            begin
                j_next     = i_reg + kpc_pkg::ADDR_W'(1);
                state_next = kpc_pkg::ST_SCAN;
            end
            kpc_pkg::ST_SCAN:
            begin
                j_next = j_reg + kpc_pkg::ADDR_W'(1);
                if (j_at_end)
                begin
                    if (i_at_end)
                    begin
                        state_next = kpc_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        i_next     = i_reg + kpc_pkg::ADDR_W'(1);
                        state_next = kpc_pkg::ST_PIVOT;
                    end
                end
            end
            kpc_pkg::ST_DRAIN:
            begin
                state_next = kpc_pkg::ST_EMIT;
            end
            kpc_pkg::ST_EMIT:
            begin
                state_next = kpc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kpc_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        busy         = (state_reg != kpc_pkg::ST_IDLE);
        cmd.store    = accept;
        cmd.rd_pivot = 1'b0;
        cmd.rd_cmp   = 1'b0;
        cmd.rd_addr  = j_reg;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            kpc_pkg::ST_PIVOT:
            begin
                cmd.rd_pivot = 1'b1;
                cmd.rd_addr  = i_reg;
            end
            kpc_pkg::ST_SCAN:
            begin
                cmd.rd_cmp  = 1'b1;
                cmd.rd_addr = j_reg;
            end
            kpc_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                cmd.rd_addr = j_reg;
            end
        endcase
    end

    // the compare index always runs ahead of the pivot
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpc_pkg::ST_SCAN) |-> (j_reg > i_reg))
        else $error("compare index not above pivot index");

    // a result is followed by a return to idle
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpc_pkg::ST_EMIT) |=> (state_reg == kpc_pkg::ST_IDLE))
        else $error("controller did not return to idle after result");

    // an item without the last mark keeps the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_pixel) |=> !busy)
        else $error("block went busy on a non-final item");

    // a pass starts only on a final item
    a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpc_pkg::ST_START) |-> $past(accept && last_pixel))
        else $error("pass started without a final item");

endmodule

`default_nettype wire

>>> hw/rtl/kpc_dp.sv
// kpc_dp: datapath with config registers, sample memories and class counters
`default_nettype none

module kpc_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [kpc_pkg::CFG_W-1:0]    cfg_data,
    input  kpc_pkg::item_t                    item,
    input  kpc_pkg::cmd_t                     cmd,
    output kpc_pkg::stat_t                    stat,
    output logic                              done,
    output kpc_pkg::result_t                  result
);

    logic signed [kpc_pkg::SAMPLE_W-1:0] nodata_first_reg;
    logic                                nodata_first_en_reg;
    logic signed [kpc_pkg::SAMPLE_W-1:0] nodata_second_reg;
    logic                                nodata_second_en_reg;

    logic [kpc_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic                        drop_reg, drop_next;
    logic                        pair_valid;
    logic                        full;
    logic                        wr_en;

    logic signed [kpc_pkg::SAMPLE_W-1:0] rd_first, rd_second;
    logic signed [kpc_pkg::SAMPLE_W-1:0] piv_first_reg, piv_second_reg;
    logic                                rd_pivot_reg, rd_cmp_reg;

    logic [kpc_pkg::CLASS_W-1:0] conc_reg, disc_reg, tie1_reg, tie2_reg, both_reg;
    logic                        f_eq, s_eq, f_gt, s_gt;
    logic                        is_conc, is_disc, is_tie1, is_tie2, is_both;

    logic                        done_reg;
    kpc_pkg::result_t            result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_first_reg     <= '0;
            nodata_first_en_reg  <= 1'b0;
            nodata_second_reg    <= '0;
            nodata_second_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (kpc_pkg::reg_index_t'(cfg_index))
                kpc_pkg::REG_NODATA_FIRST:     nodata_first_reg     <= cfg_data;
                kpc_pkg::REG_NODATA_FIRST_EN:  nodata_first_en_reg  <= cfg_data[0];
                kpc_pkg::REG_NODATA_SECOND:    nodata_second_reg    <= cfg_data;
                kpc_pkg::REG_NODATA_SECOND_EN: nodata_second_en_reg <= cfg_data[0];
                default:                       nodata_first_en_reg  <= nodata_first_en_reg;
            endcase
        end
    end

    // no-data filter and store decision
    assign pair_valid = !(nodata_first_en_reg && (item.first_sample == nodata_first_reg))
                     && !(nodata_second_en_reg && (item.second_sample == nodata_second_reg));
    assign full  = (fill_reg == kpc_pkg::FILL_W'(kpc_pkg::CAPACITY));
    assign wr_en = cmd.store && pair_valid && !full;

    always_comb
    begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        if (cmd.emit)
        begin
            fill_next = '0;
            drop_next = 1'b0;
        end
        else if (cmd.store && pair_valid)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + kpc_pkg::FILL_W'(1);
            end
        end
    end

    // fill count and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            drop_reg <= drop_next;
        end
    end

    assign stat.fill = fill_reg;

    // sample memories
    kpc_ram #(
        .WIDTH (kpc_pkg::SAMPLE_W),
        .DEPTH (kpc_pkg::CAPACITY)
    ) u_first_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (fill_reg[kpc_pkg::ADDR_W-1:0]),
        .wdata (item.first_sample),
        .raddr (cmd.rd_addr),
        .rdata (rd_first)
    );

    kpc_ram #(
        .WIDTH (kpc_pkg::SAMPLE_W),
        .DEPTH (kpc_pkg::CAPACITY)
    ) u_second_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (fill_reg[kpc_pkg::ADDR_W-1:0]),
        .wdata (item.second_sample),
        .raddr (cmd.rd_addr),
        .rdata (rd_second)
    );

    // read tags follow the memory latency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pivot_reg <= 1'b0;
            rd_cmp_reg   <= 1'b0;
        end
        else
        begin
            rd_pivot_reg <= cmd.rd_pivot;
            rd_cmp_reg   <= cmd.rd_cmp;
        end
    end

    // pivot entry hold
    always_ff @(posedge clk)
    begin
        if (rd_pivot_reg)
        begin
            piv_first_reg  <= rd_first;
            piv_second_reg <= rd_second;
        end
    end

    // classify the compare entry against the pivot
    assign f_eq = (rd_first == piv_first_reg);
    assign s_eq = (rd_second == piv_second_reg);
    assign f_gt = (rd_first > piv_first_reg);
    assign s_gt = (rd_second > piv_second_reg);

    assign is_both = rd_cmp_reg && f_eq && s_eq;
    assign is_tie1 = rd_cmp_reg && f_eq && !s_eq;
    assign is_tie2 = rd_cmp_reg && !f_eq && s_eq;
    assign is_conc = rd_cmp_reg && !f_eq && !s_eq && (f_gt == s_gt);
    assign is_disc = rd_cmp_reg && !f_eq && !s_eq && (f_gt != s_gt);

    // saturating class counters, cleared with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conc_reg <= '0;
            disc_reg <= '0;
            tie1_reg <= '0;
            tie2_reg <= '0;
            both_reg <= '0;
        end
        else if (cmd.emit)
        begin
            conc_reg <= '0;
            disc_reg <= '0;
            tie1_reg <= '0;
            tie2_reg <= '0;
            both_reg <= '0;
        end
        else
        begin
            if (is_conc && (conc_reg != kpc_pkg::CLASS_MAX))
            begin
                conc_reg <= conc_reg + kpc_pkg::CLASS_W'(1);
            end
            if (is_disc && (disc_reg != kpc_pkg::CLASS_MAX))
            begin
                disc_reg <= disc_reg + kpc_pkg::CLASS_W'(1);
            end
            if (is_tie1 && (tie1_reg != kpc_pkg::CLASS_MAX))
            begin
                tie1_reg <= tie1_reg + kpc_pkg::CLASS_W'(1);
            end
            if (is_tie2 && (tie2_reg != kpc_pkg::CLASS_MAX))
            begin
                tie2_reg <= tie2_reg + kpc_pkg::CLASS_W'(1);
            end
            if (is_both && (both_reg != kpc_pkg::CLASS_MAX))
            begin
                both_reg <= both_reg + kpc_pkg::CLASS_W'(1);
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    // result record, counters are zero when fewer than two pairs were kept
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.pair_count       <= kpc_pkg::PAIRS_W'(fill_reg);
            result_reg.concordant_count <= conc_reg;
            result_reg.discordant_count <= disc_reg;
            result_reg.tied_first_only  <= tie1_reg;
            result_reg.tied_second_only <= tie2_reg;
            result_reg.tied_both        <= both_reg;
            result_reg.overflowed       <= drop_reg;
            result_reg.status           <= (fill_reg < kpc_pkg::FILL_W'(2));
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // pivot load and compare never share a cycle
    a_tag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_pivot_reg && rd_cmp_reg))
        else $error("pivot load and compare in the same cycle");

    // frame state is cleared when the result goes out
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((fill_reg == '0) && !drop_reg && (conc_reg == '0)))
        else $error("frame state not cleared with the result");

    // the fill count never passes capacity
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= kpc_pkg::FILL_W'(kpc_pkg::CAPACITY))
        else $error("fill count above capacity");

endmodule

`default_nettype wire

>>> hw/rtl/kendall_pair_counter.sv
// kendall_pair_counter: top level joining the controller and the datapath
//
// Pixel pairs are taken one per clock while busy is low: a transfer happens
// on each edge with start high and busy low. Pairs with an enabled no-data
// value are dropped; up to 4096 valid pairs are kept in two sample memories,
// and later valid pairs set the overflowed flag. A pair marked last_pixel
// starts the pairwise pass, during which busy stays high: a start step, then
// for each pivot but the last a pivot read and compare reads of each later
// pair, then a drain step and the result latch, which follows the start step
// at once with fewer than two pairs. The single read port of the sample
// memories allows one compare per cycle while a pivot is scanned. The result
// is shown for one cycle with done high, the cycle after busy falls, and must
// be taken then, as the receiver cannot stall it; busy is already low in that
// cycle, so the next frame may start at once. No clearing pass follows reset.
`default_nettype none

module kendall_pair_counter (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  kpc_pkg::item_t                 item,
    output logic                           done,
    output kpc_pkg::result_t               result,
    input  wire logic                      cfg_write,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [kpc_pkg::CFG_W-1:0] cfg_data
);

    kpc_pkg::cmd_t  cmd;
    kpc_pkg::stat_t stat;

    // sequencing
    kpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_pixel (item.last_pixel),
        .stat       (stat),
        .busy       (busy),
        .cmd        (cmd)
    );

    // storage and counting
    kpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> tb/sv/kendall_pair_counter_tb.sv
// kendall_pair_counter_tb: self-checking testbench for the kendall pair counter
`timescale 1ns / 1ps

module kendall_pair_counter_tb;

    localparam int          SETTLE_CYCLES = 8;
    localparam longint      CYCLE_LIMIT   = 1_000_000;
    localparam logic signed [kpc_pkg::SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [kpc_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

    // one queued pixel pair with the idle cycles that come before it
    typedef struct {
        kpc_pkg::item_t px;
        int unsigned    gap;
    } pixel_entry_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      busy;
    kpc_pkg::item_t            item      = '0;
    logic                      done;
    kpc_pkg::result_t          result;
    logic                      cfg_write = 1'b0;
    logic [1:0]                cfg_index = 2'd0;
    logic [kpc_pkg::CFG_W-1:0] cfg_data  = '0;

    // pending pixel pairs and the tallies still owed by the block
    pixel_entry_t       pixel_queue[$];
    kpc_pkg::result_t   expected_tallies[$];
    pixel_entry_t       next_entry;
    bit                 have_next;
    longint unsigned    queued_total;
    longint unsigned    accepted_total;
    int                 mismatches;
    longint             cycle_count;

    // model copy of the no-data registers
    logic signed [kpc_pkg::SAMPLE_W-1:0] hold_first;
    logic                                hold_first_en;
    logic signed [kpc_pkg::SAMPLE_W-1:0] hold_second;
    logic                                hold_second_en;

    // model copy of the kept pairs of the current frame
    logic signed [kpc_pkg::SAMPLE_W-1:0] kept_first [kpc_pkg::CAPACITY];
    logic signed [kpc_pkg::SAMPLE_W-1:0] kept_second [kpc_pkg::CAPACITY];
    int                                  kept_n;
    logic                                spilled;

    kendall_pair_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // true when an enabled no-data value knocks the pair out
    function automatic bit is_dropped(kpc_pkg::item_t px);
        return (hold_first_en && px.first_sample == hold_first) ||
               (hold_second_en && px.second_sample == hold_second);
    endfunction

    // classify every pair of kept pairs and build the tally record
    function automatic kpc_pkg::result_t tally_frame();
        kpc_pkg::result_t            res;
        logic [kpc_pkg::CLASS_W-1:0] conc, disc, tie_a, tie_b, tie_ab;
        conc = '0;
        disc = '0;
        tie_a = '0;
        tie_b = '0;
        tie_ab = '0;
        for (int i = 0; i + 1 < kept_n; i++)
        begin
            for (int j = i + 1; j < kept_n; j++)
            begin
                if (kept_first[j] == kept_first[i] && kept_second[j] == kept_second[i])
                begin
                    if (tie_ab != kpc_pkg::CLASS_MAX) tie_ab++;
                end
                else if (kept_first[j] == kept_first[i])
                begin
                    if (tie_a != kpc_pkg::CLASS_MAX) tie_a++;
                end
                else if (kept_second[j] == kept_second[i])
                begin
                    if (tie_b != kpc_pkg::CLASS_MAX) tie_b++;
                end
                else if ((kept_first[j] > kept_first[i]) ==
                         (kept_second[j] > kept_second[i]))
                begin
                    if (conc != kpc_pkg::CLASS_MAX) conc++;
                end
                else
                begin
                    if (disc != kpc_pkg::CLASS_MAX) disc++;
                end
            end
        end
        res.pair_count       = (kept_n > 8191) ? kpc_pkg::PAIRS_W'(8191)
                                               : kpc_pkg::PAIRS_W'(kept_n);
        res.concordant_count = conc;
        res.discordant_count = disc;
        res.tied_first_only  = tie_a;
        res.tied_second_only = tie_b;
        res.tied_both        = tie_ab;
        res.overflowed       = spilled;
        res.status           = (kept_n < 2);
        return res;
    endfunction

    // predict the effect of one accepted pixel pair
    function automatic void model_pixel(kpc_pkg::item_t px);
        if (!is_dropped(px))
        begin
            if (kept_n < kpc_pkg::CAPACITY)
            begin
                kept_first[kept_n]  = px.first_sample;
                kept_second[kept_n] = px.second_sample;
                kept_n++;
            end
            else
            begin
                spilled = 1'b1;
            end
        end
        if (px.last_pixel)
        begin
            expected_tallies = {expected_tallies, tally_frame()};
            kept_n  = 0;
            spilled = 1'b0;
        end
    endfunction

    function automatic kpc_pkg::item_t make_pixel(logic signed [kpc_pkg::SAMPLE_W-1:0] a,
                                                  logic signed [kpc_pkg::SAMPLE_W-1:0] b,
                                                  logic last);
        kpc_pkg::item_t px;
        px.first_sample  = a;
        px.second_sample = b;
        px.last_pixel    = last;
        return px;
    endfunction

    function automatic void queue_pixel(kpc_pkg::item_t px, int unsigned gap);
        pixel_entry_t e;
        e.px  = px;
        e.gap = gap;
        pixel_queue = {pixel_queue, e};
        queued_total++;
    endfunction

    // sample mix: narrow range for ties, the no-data marker, extremes, full range
    function automatic logic signed [kpc_pkg::SAMPLE_W-1:0] draw_sample(
            logic signed [kpc_pkg::SAMPLE_W-1:0] marker);
        int v;
        case ($urandom_range(0, 9)) inside
            [0:3]:
            begin
                v = int'($urandom_range(0, 4)) - 2;
                return v;
            end
            [4:5]:   return marker;
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // random frames until enough kept pairs have been queued
    task automatic queue_random_frames(int unsigned target);
        int unsigned    counted;
        int unsigned    len;
        bit             bursty;
        kpc_pkg::item_t px;
        counted = 0;
        while (counted < target)
        begin
            len    = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            bursty = ($urandom_range(0, 3) == 0);
            for (int unsigned k = 0; k < len; k++)
            begin
                px = make_pixel(draw_sample(hold_first), draw_sample(hold_second),
                                k == len - 1);
                queue_pixel(px, bursty ? 0 : $urandom_range(0, 16));
                if (!is_dropped(px)) counted++;
            end
        end
    endtask

    // hold off until every queued pair is taken and every tally has come
    task automatic drain_and_settle();
        while (accepted_total != queued_total || expected_tallies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, mirrored into the model copy
    task automatic write_reg(kpc_pkg::reg_index_t idx, logic [kpc_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            kpc_pkg::REG_NODATA_FIRST:     hold_first     = val;
            kpc_pkg::REG_NODATA_FIRST_EN:  hold_first_en  = val[0];
            kpc_pkg::REG_NODATA_SECOND:    hold_second    = val;
            kpc_pkg::REG_NODATA_SECOND_EN: hold_second_en = val[0];
            default: ;
        endcase
    endtask

    task automatic write_enables(logic first_en, logic second_en);
        write_reg(kpc_pkg::REG_NODATA_FIRST_EN, {31'($urandom), first_en});
        write_reg(kpc_pkg::REG_NODATA_SECOND_EN, {31'($urandom), second_en});
    endtask

    // driver: one transfer per start high with busy low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            item      <= '0;
            have_next = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                model_pixel(item);
                accepted_total++;
            end
            if (!start || !busy)
            begin
                if (!have_next && pixel_queue.size() != 0)
                begin
                    next_entry = pixel_queue.pop_front();
                    have_next  = 1'b1;
                end
                if (have_next && next_entry.gap == 0)
                begin
                    start     <= 1'b1;
                    item      <= next_entry.px;
                    have_next = 1'b0;
                end
                else
                begin
                    if (have_next) next_entry.gap--;
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // monitor: every done strobe is one tally transfer
    always @(posedge clk)
    begin
        kpc_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_tallies.size() == 0)
            begin
                $error("tally transfer with none expected");
                mismatches++;
            end
            else
            begin
                want = expected_tallies.pop_front();
                check_field("pair_count", want.pair_count, result.pair_count);
                check_field("concordant_count", want.concordant_count,
                            result.concordant_count);
                check_field("discordant_count", want.discordant_count,
                            result.discordant_count);
                check_field("tied_first_only", want.tied_first_only,
                            result.tied_first_only);
                check_field("tied_second_only", want.tied_second_only,
                            result.tied_second_only);
                check_field("tied_both", want.tied_both, result.tied_both);
                check_field("overflowed", want.overflowed, result.overflowed);
                check_field("status", want.status, result.status);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        hold_first     = '0;
        hold_first_en  = 1'b0;
        hold_second    = '0;
        hold_second_en = 1'b0;
        kept_n         = 0;
        spilled        = 1'b0;
        queued_total   = 0;
        accepted_total = 0;
        mismatches     = 0;
        cycle_count    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: checks off, zero samples are kept
        queue_pixel(make_pixel(5, -3, 1'b1), 0);
        queue_pixel(make_pixel(S_MIN, S_MAX, 1'b0), 0);
        queue_pixel(make_pixel(S_MAX, S_MIN, 1'b0), 0);
        queue_pixel(make_pixel(0, 0, 1'b0), 0);
        queue_pixel(make_pixel(0, 0, 1'b0), 3);
        queue_pixel(make_pixel(0, 9, 1'b0), 0);
        queue_pixel(make_pixel(-1, 0, 1'b0), 1);
        queue_pixel(make_pixel(-1, -1, 1'b1), 0);
        queue_pixel(make_pixel(1, 1, 1'b0), 0);
        queue_pixel(make_pixel(2, 2, 1'b1), 0);
        drain_and_settle();

        // both checks on at the extremes
        write_reg(kpc_pkg::REG_NODATA_FIRST, S_MIN);
        write_reg(kpc_pkg::REG_NODATA_SECOND, S_MAX);
        write_enables(1'b1, 1'b1);
        // every pair dropped, the dropped last pair still closes the frame
        queue_pixel(make_pixel(S_MIN, 3, 1'b0), 0);
        queue_pixel(make_pixel(4, S_MAX, 1'b1), 2);
        // mixed drops
        queue_pixel(make_pixel(1, 2, 1'b0), 0);
        queue_pixel(make_pixel(S_MIN, S_MIN, 1'b0), 0);
        queue_pixel(make_pixel(3, -5, 1'b0), 0);
        queue_pixel(make_pixel(S_MAX, S_MAX, 1'b0), 0);
        queue_pixel(make_pixel(S_MAX, S_MIN, 1'b1), 0);
        queue_random_frames(75);
        drain_and_settle();

        // first check only, marker in the narrow range
        write_reg(kpc_pkg::REG_NODATA_FIRST, 32'(int'($urandom_range(0, 4)) - 2));
        write_reg(kpc_pkg::REG_NODATA_SECOND, $urandom);
        write_enables(1'b1, 1'b0);
        queue_random_frames(75);
        drain_and_settle();

        // checks off
        write_reg(kpc_pkg::REG_NODATA_FIRST, S_MAX);
        write_reg(kpc_pkg::REG_NODATA_SECOND, '0);
        write_enables(1'b0, 1'b0);
        queue_random_frames(75);
        drain_and_settle();

        // second check only
        write_reg(kpc_pkg::REG_NODATA_SECOND, 32'(int'($urandom_range(0, 4)) - 2));
        write_enables(1'b0, 1'b1);
        queue_random_frames(75);
        drain_and_settle();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
